/* sv/scpr_pkg.sv */
// Shared constants and types for the second-chance page replacement block.
package scpr_pkg;

  localparam int TABLE_SLOTS = 64;
  localparam int PAGE_BITS   = 16;
  localparam int SLOT_W      = 6;
  localparam int ACT_W       = 7;
  localparam int CNT_W       = 32;

  localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(TABLE_SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOK   = 3'b010,
    ST_UPDATE = 3'b100
  } state_e;

  typedef enum logic [1:0] {
    SW_HI  = 2'd0,
    SW_LO  = 2'd1,
    SW_ALL = 2'd2
  } sweep_e;

  typedef struct packed {
    logic [PAGE_BITS-1:0] key;
    logic [ACT_W-1:0]     n;
    logic [SLOT_W-1:0]    hand;
    logic [SLOT_W-1:0]    victim;
    sweep_e               mode;
    logic                 update;
    logic                 hit;
    logic [SLOT_W-1:0]    hit_slot;
  } cmd_t;

  typedef struct packed {
    logic                 hit_seen;
    logic [SLOT_W-1:0]    hit_slot;
    logic                 hi_seen;
    logic [SLOT_W-1:0]    hi_slot;
    logic                 lo_seen;
    logic [SLOT_W-1:0]    lo_slot;
    logic                 ev_valid;
    logic [PAGE_BITS-1:0] ev_page;
  } chain_t;

endpackage

/* sv/scpr_if.sv */
// Valid/ready channel interfaces for page accesses and replacement results.
interface scpr_in_if;
  logic                           valid;
  logic                           ready;
  logic [scpr_pkg::PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink (input valid, input page_number, output ready);
endinterface

interface scpr_out_if;
  logic                           valid;
  logic                           ready;
  logic                           was_hit;
  logic [scpr_pkg::SLOT_W-1:0]    slot_used;
  logic                           evicted_valid;
  logic [scpr_pkg::PAGE_BITS-1:0] evicted_page;
  logic [scpr_pkg::CNT_W-1:0]     hits_so_far;
  logic [scpr_pkg::CNT_W-1:0]     misses_so_far;

  modport source (output valid, output was_hit, output slot_used, output evicted_valid,
                  output evicted_page, output hits_so_far, output misses_so_far,
                  input ready);
  modport sink (input valid, input was_hit, input slot_used, input evicted_valid,
                input evicted_page, input hits_so_far, input misses_so_far,
                output ready);
endinterface

/* sv/scpr_cell.sv */
// One page slot: stored page, valid and reference bits, and its link of the search chain.
module scpr_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [scpr_pkg::SLOT_W-1:0] slot_idx_i,
  input  scpr_pkg::cmd_t             cmd_i,
  input  scpr_pkg::chain_t           chain_i,
  output scpr_pkg::chain_t           chain_o
);
  import scpr_pkg::*;

  logic [PAGE_BITS-1:0] page_q, page_d;
  logic                 valid_q, valid_d;
  logic                 ref_q, ref_d;

  logic in_range, match, free, upper;
  logic hit_sel, hi_sel, lo_sel, is_victim, in_sweep;

  always_comb begin
    in_range  = {1'b0, slot_idx_i} < cmd_i.n;
    match     = in_range && valid_q && (page_q == cmd_i.key);
    free      = in_range && !ref_q;
    upper     = slot_idx_i >= cmd_i.hand;
    hit_sel   = match && !chain_i.hit_seen;
    hi_sel    = free && upper && !chain_i.hi_seen;
    lo_sel    = free && !upper && !chain_i.lo_seen;
    is_victim = !cmd_i.hit && (slot_idx_i == cmd_i.victim);

    chain_o.hit_seen = chain_i.hit_seen | match;
    chain_o.hit_slot = chain_i.hit_slot | (hit_sel ? slot_idx_i : '0);
    chain_o.hi_seen  = chain_i.hi_seen | (free && upper);
    chain_o.hi_slot  = chain_i.hi_slot | (hi_sel ? slot_idx_i : '0);
    chain_o.lo_seen  = chain_i.lo_seen | (free && !upper);
    chain_o.lo_slot  = chain_i.lo_slot | (lo_sel ? slot_idx_i : '0);
    chain_o.ev_valid = chain_i.ev_valid | (is_victim && valid_q);
    chain_o.ev_page  = chain_i.ev_page | ((is_victim && valid_q) ? page_q : '0);

    case (cmd_i.mode)
      SW_HI:   in_sweep = upper && (slot_idx_i < cmd_i.victim);
      SW_LO:   in_sweep = upper || (slot_idx_i < cmd_i.victim);
      SW_ALL:  in_sweep = 1'b1;
      default: in_sweep = 1'b0;
    endcase
    in_sweep = in_sweep && in_range;

    page_d  = page_q;
    valid_d = valid_q;
    ref_d   = ref_q;
    if (cmd_i.update) begin
      if (cmd_i.hit) begin
        if (slot_idx_i == cmd_i.hit_slot) begin
          ref_d = 1'b1;
        end
      end else if (is_victim) begin
        page_d  = cmd_i.key;
        valid_d = 1'b1;
        ref_d   = 1'b0;
      end else if (in_sweep) begin
        ref_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ref_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      ref_q   <= ref_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

endmodule

/* sv/second_chance_page_replacement_top.sv */
// Top level: second-chance page table built from a row of slot cells and a sequencer.
//
//   channel  dir  fields                                   accepted when
//   in_i     in   page_number                              valid && ready
//   out_o    out  was_hit slot_used evicted_valid          valid && ready
//                 evicted_page hits_so_far misses_so_far
//   cfg      in   cfg_wdata_i (active_slots)               cfg_we_i
//
// Each access passes through three steps: accept, chain lookup and sweep search, table update.
// The lookup and the clock sweep resolve in one pass along the slot chain.
// A result waits in the output register; the next access is taken meanwhile, and its
// update holds until that result is taken.
// Reset clears all valid and reference bits, the hand and both counts at once.
module second_chance_page_replacement_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [scpr_pkg::ACT_W-1:0]  cfg_wdata_i,
  scpr_in_if.sink                     in_i,
  scpr_out_if.source                  out_o
);
  import scpr_pkg::*;

  state_e               state_q, state_d;
  logic [ACT_W-1:0]     active_q;
  logic [SLOT_W-1:0]    hand_q;
  logic [PAGE_BITS-1:0] key_q;
  logic                 hit_q;
  logic [SLOT_W-1:0]    hit_slot_q;
  logic [SLOT_W-1:0]    victim_q;
  sweep_e               mode_q;
  logic [CNT_W-1:0]     hit_total_q, miss_total_q;

  logic                 out_valid_q;
  logic                 out_hit_q;
  logic [SLOT_W-1:0]    out_slot_q;
  logic                 out_ev_valid_q;
  logic [PAGE_BITS-1:0] out_ev_page_q;

  logic [ACT_W-1:0]     n_eff;
  logic [SLOT_W-1:0]    hand_eff;
  logic [ACT_W-1:0]     victim_inc;
  logic [SLOT_W-1:0]    hand_next;
  logic                 upd_fire;
  cmd_t                 cmd;
  chain_t               chain [TABLE_SLOTS+1];

  always_comb begin
    if (active_q == '0) begin
      n_eff = ACT_W'(1);
    end else if (active_q > ACT_W'(TABLE_SLOTS)) begin
      n_eff = ACT_W'(TABLE_SLOTS);
    end else begin
      n_eff = active_q;
    end
    hand_eff   = ({1'b0, hand_q} >= n_eff) ? '0 : hand_q;
    victim_inc = {1'b0, victim_q} + ACT_W'(1);
    hand_next  = (victim_inc >= n_eff) ? '0 : victim_inc[SLOT_W-1:0];
    upd_fire   = (state_q == ST_UPDATE) && (!out_valid_q || out_o.ready);

    cmd.key      = key_q;
    cmd.n        = n_eff;
    cmd.hand     = hand_eff;
    cmd.victim   = victim_q;
    cmd.mode     = mode_q;
    cmd.update   = upd_fire;
    cmd.hit      = hit_q;
    cmd.hit_slot = hit_slot_q;
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
    scpr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .slot_idx_i (SLOT_W'(g)),
      .cmd_i      (cmd),
      .chain_i    (chain[g]),
      .chain_o    (chain[g+1])
    );
  end

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    case (state_q)
      ST_IDLE:   state_d = (in_i.valid) ? ST_LOOK : ST_IDLE;
      ST_LOOK:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = upd_fire ? ST_IDLE : ST_UPDATE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      active_q     <= ACT_RESET;
      hand_q       <= '0;
      hit_total_q  <= '0;
      miss_total_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (upd_fire) begin
        out_valid_q <= 1'b1;
        if (hit_q) begin
          if (hit_total_q != '1) begin
            hit_total_q <= hit_total_q + CNT_W'(1);
          end
        end else begin
          hand_q <= hand_next;
          if (miss_total_q != '1) begin
            miss_total_q <= miss_total_q + CNT_W'(1);
          end
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      key_q <= in_i.page_number;
    end
    if (state_q == ST_LOOK) begin
      hit_q      <= chain[TABLE_SLOTS].hit_seen;
      hit_slot_q <= chain[TABLE_SLOTS].hit_slot;
      if (chain[TABLE_SLOTS].hi_seen) begin
        victim_q <= chain[TABLE_SLOTS].hi_slot;
        mode_q   <= SW_HI;
      end else if (chain[TABLE_SLOTS].lo_seen) begin
        victim_q <= chain[TABLE_SLOTS].lo_slot;
        mode_q   <= SW_LO;
      end else begin
        victim_q <= hand_eff;
        mode_q   <= SW_ALL;
      end
    end
    if (upd_fire) begin
      out_hit_q      <= hit_q;
      out_slot_q     <= hit_q ? hit_slot_q : victim_q;
      out_ev_valid_q <= !hit_q && chain[TABLE_SLOTS].ev_valid;
      out_ev_page_q  <= hit_q ? '0 : chain[TABLE_SLOTS].ev_page;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.was_hit       = out_hit_q;
  assign out_o.slot_used     = out_slot_q;
  assign out_o.evicted_valid = out_ev_valid_q;
  assign out_o.evicted_page  = out_ev_page_q;
  assign out_o.hits_so_far   = hit_total_q;
  assign out_o.misses_so_far = miss_total_q;

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire |=> out_o.valid)
    else $error("update did not present a result");

  a_miss_keeps_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && !hit_q) |=> (hit_total_q == $past(hit_total_q)) && !out_o.was_hit)
    else $error("miss changed hit count");

  a_hit_keeps_hand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upd_fire && hit_q) |=> (hand_q == $past(hand_q)) && !out_o.evicted_valid)
    else $error("hit moved the hand or evicted a page");

endmodule

/* verif/scpr_checker.sv */
// Checker that predicts each page access outcome and compares it with the block's results.
module scpr_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [scpr_pkg::ACT_W-1:0] cfg_wdata_i,
  scpr_in_if                         acc_mon,
  scpr_out_if                        res_mon,
  output int                         mismatches,
  output int                         outstanding,
  output int                         accesses_seen,
  output int                         hits_seen,
  output int                         evictions_seen
);
  import scpr_pkg::*;

  typedef struct packed {
    logic                 was_hit;
    logic [SLOT_W-1:0]    slot;
    logic                 ev_valid;
    logic [PAGE_BITS-1:0] ev_page;
    logic [CNT_W-1:0]     hits;
    logic [CNT_W-1:0]     misses;
  } outcome_t;

  logic [PAGE_BITS-1:0] page_at      [TABLE_SLOTS];
  logic                 occupied     [TABLE_SLOTS];
  logic                 second_chance[TABLE_SLOTS];
  int                   sweep_pos;
  logic [CNT_W-1:0]     hit_tally;
  logic [CNT_W-1:0]     fault_tally;
  logic [ACT_W-1:0]     slots_cfg;
  outcome_t             outcome_q[$];

  function automatic outcome_t access_table(input logic [PAGE_BITS-1:0] pg);
    outcome_t o;
    int       n;
    int       h;
    bit       found;
    n = (slots_cfg == 0) ? 1 : ((slots_cfg > TABLE_SLOTS) ? TABLE_SLOTS : int'(slots_cfg));
    o = '0;
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && occupied[i] && page_at[i] == pg) begin
        found = 1'b1;
        o.slot = SLOT_W'(i);
      end
    end
    if (found) begin
      second_chance[o.slot] = 1'b1;
      if (hit_tally != '1) hit_tally++;
      o.was_hit = 1'b1;
    end else begin
      h = (sweep_pos >= n) ? 0 : sweep_pos;
      for (int i = 0; i < n; i++) begin
        if (!second_chance[h]) break;
        second_chance[h] = 1'b0;
        h = (h + 1 >= n) ? 0 : h + 1;
      end
      o.slot = SLOT_W'(h);
      if (occupied[h]) begin
        o.ev_valid = 1'b1;
        o.ev_page  = page_at[h];
      end
      page_at[h]       = pg;
      occupied[h]      = 1'b1;
      second_chance[h] = 1'b0;
      sweep_pos = (h + 1 >= n) ? 0 : h + 1;
      if (fault_tally != '1) fault_tally++;
    end
    o.hits   = hit_tally;
    o.misses = fault_tally;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t w;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        occupied[i]      = 1'b0;
        second_chance[i] = 1'b0;
      end
      sweep_pos      = 0;
      hit_tally      = '0;
      fault_tally    = '0;
      slots_cfg      = ACT_RESET;
      outcome_q.delete();
      mismatches     = 0;
      outstanding    = 0;
      accesses_seen  = 0;
      hits_seen      = 0;
      evictions_seen = 0;
    end else begin
      if (cfg_we_i) slots_cfg = cfg_wdata_i;
      if (acc_mon.valid && acc_mon.ready) outcome_q.push_back(access_table(acc_mon.page_number));
      if (res_mon.valid && res_mon.ready) begin
        if (outcome_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual slot %0d hit %0b",
                   $time, res_mon.slot_used, res_mon.was_hit);
        end else begin
          w = outcome_q.pop_front();
          accesses_seen++;
          if (w.was_hit) hits_seen++;
          if (w.ev_valid) evictions_seen++;
          check_field("was_hit", w.was_hit, res_mon.was_hit);
          check_field("slot_used", w.slot, res_mon.slot_used);
          check_field("evicted_valid", w.ev_valid, res_mon.evicted_valid);
          check_field("evicted_page", w.ev_page, res_mon.evicted_page);
          check_field("hits_so_far", w.hits, res_mon.hits_so_far);
          check_field("misses_so_far", w.misses, res_mon.misses_so_far);
        end
      end
      outstanding = outcome_q.size();
    end
  end

endmodule

/* verif/second_chance_page_replacement_top_tb.sv */
// Testbench top: drives page accesses and slot-count writes, and reports the verdict.
module second_chance_page_replacement_top_tb;
  import scpr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 45;
  localparam int POOL_SIZE   = 128;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [ACT_W-1:0] cfg_wdata_i;

  int mismatches;
  int outstanding;
  int accesses_seen;
  int hits_seen;
  int evictions_seen;
  int cycles = 0;
  int settings_done;
  bit calm;

  logic [PAGE_BITS-1:0] page_pool[POOL_SIZE];

  scpr_in_if  in_if();
  scpr_out_if out_if();

  second_chance_page_replacement_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  scpr_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .acc_mon        (in_if),
    .res_mon        (out_if),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .accesses_seen  (accesses_seen),
    .hits_seen      (hits_seen),
    .evictions_seen (evictions_seen)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  task automatic send_page(input logic [PAGE_BITS-1:0] pg);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.page_number <= pg;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_slots(input logic [ACT_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_done++;
  endtask

  initial begin : sink_side
    int w;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      w = pick_gap();
      if (w > 0) begin
        out_if.ready <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin : source_side
    int               live;
    int               r;
    logic [ACT_W-1:0] sel;
    logic [PAGE_BITS-1:0] prev;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    in_if.valid       = 1'b0;
    in_if.page_number = '0;
    settings_done     = 0;
    calm              = 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) page_pool[i] = PAGE_BITS'($urandom);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'hAAAA);
    send_page(16'h5555);
    // shrink below the hand, then force a full sweep
    write_slots(ACT_W'(2));
    send_page(16'h1234);
    send_page(16'h0000);
    send_page(16'hAAAA);
    // grow back: two slots now hold the same page
    write_slots(ACT_W'(64));
    send_page(16'hAAAA);
    send_page(16'h5555);
    write_slots(ACT_W'(0));
    send_page(16'h0001);
    send_page(16'h0002);
    send_page(16'h0002);
    send_page(16'h0003);
    send_page(16'h0003);
    send_page(16'h0004);
    write_slots(ACT_W'(127));
    send_page(16'h00FF);
    send_page(16'hFF00);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: sel = ACT_W'(1);
        1: sel = ACT_W'(64);
        2: sel = ACT_W'(127);
        3: sel = ACT_W'(0);
        default: begin
          sel = ($urandom_range(0, 99) < 70) ? ACT_W'($urandom_range(2, 63))
                                              : ACT_W'($urandom_range(65, 127));
        end
      endcase
      write_slots(sel);
      calm = (p % 3 == 2);
      live = (sel == 0) ? 1 : ((sel > TABLE_SLOTS) ? TABLE_SLOTS : int'(sel));
      live = live + live / 2 + 2;
      if (live > POOL_SIZE) live = POOL_SIZE;
      live = $urandom_range(1, live);
      prev = page_pool[0];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 15) prev = PAGE_BITS'($urandom);
        else if (r < 30) prev = prev;
        else prev = page_pool[$urandom_range(0, live - 1)];
        send_page(prev);
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("checked %0d page accesses: %0d hits, %0d evictions, %0d slot-count writes",
             accesses_seen, hits_seen, evictions_seen, settings_done);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
